// ----- rtl/core/bbd_pkg.sv -----
// Shared types, constants and helper functions of the Bayer bilinear demosaic unit.
`default_nettype none

package bbd_pkg;

  // Widths fixed by the register and field definitions.
  localparam int CFG_W  = 12;  // configuration register width
  localparam int ROW_W  = 13;  // row counters wrap at this width
  localparam int PIX_W  = 8;   // one colour component or raw sample
  localparam int SUM_W  = 10;  // sum of up to four samples
  localparam int CNT_W  = 3;   // count of up to four neighbours
  localparam int RGB_W  = 3 * PIX_W;

  localparam int DEF_MAX_WIDTH = 2048;

  localparam logic [CFG_W-1:0] FRAME_WIDTH_RST  = 12'd640;
  localparam logic [CFG_W-1:0] FRAME_HEIGHT_RST = 12'd480;
  localparam logic [CFG_W-1:0] MIN_DIM          = 12'd2;

  // Command queue between the front and the back end.
  localparam int FIFO_DEPTH = 4;
  localparam int FIFO_PW    = $clog2(FIFO_DEPTH);

  // floor(x / 3) == (x * 683) >> 11 for every sum of up to four samples.
  localparam logic [SUM_W-1:0] DIV3_MUL   = 10'd683;
  localparam int               DIV3_SHIFT = 11;

  typedef enum logic {
    REQ_SAMPLE = 1'b0,
    REQ_DRAIN  = 1'b1
  } req_type_t;

  typedef enum logic [0:0] {
    REG_FRAME_WIDTH  = 1'b0,
    REG_FRAME_HEIGHT = 1'b1
  } cfg_reg_t;

  typedef enum logic [1:0] {
    COL_RED   = 2'd0,
    COL_GREEN = 2'd1,
    COL_BLUE  = 2'd2
  } colour_t;

  // Position of the output pixel as the back end needs it.
  typedef struct packed {
    logic row_odd;
    logic col_odd;
    logic top;
    logic bottom;
    logic left;
    logic right;
    logic row_end;
    logic frame_end;
  } pos_info_t;

  // One unit of work for the back end: push a sample, optionally emit a pixel.
  typedef struct packed {
    logic [PIX_W-1:0] sample;
    logic             emit;
    pos_info_t        pos;
  } cmd_t;

  typedef struct packed {
    logic full;
    logic empty;
  } fifo_stat_t;

  // GBRG layout: even rows G B G B, odd rows R G R G.
  function automatic colour_t site_colour(input logic row_odd, input logic col_odd);
    colour_t c;
    if (!row_odd) begin
      c = col_odd ? COL_BLUE : COL_GREEN;
    end else begin
      c = col_odd ? COL_GREEN : COL_RED;
    end
    return c;
  endfunction

endpackage

`default_nettype wire

// ----- rtl/core/bayer_bilinear_demosaic_unit.sv -----
// Top level of the GBRG Bayer bilinear demosaic unit.
//
//   channel  direction  handshake          payload
//   in_      input      tvalid / tready    tdata = raw_sample, tuser = req_type
//   out_     output     tvalid / tready    tdata = {blue, green, red}, tlast = row_end,
//                                          tuser = frame_end
//   cfg_     input      cfg_we only        cfg_index selects register, cfg_wdata
//
// One item is taken per cycle while the queue has room; the back end retires one
// command per cycle unless the output stalls. A pixel leaves via stages A to D after
// the item releasing it, which comes frame_width items after its own position's sample.
// Reset is synchronous and active low; it clears counters, the window and the queue,
// but not the line stores, which need no clearing.
// A stall on the output holds the pipeline and, once the four-entry queue fills,
// drops in_tready.
`default_nettype none

module bayer_bilinear_demosaic_unit import bbd_pkg::*; #(
  parameter int MAX_WIDTH = DEF_MAX_WIDTH
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             in_tvalid,
  output logic                  in_tready,
  input  wire logic             in_tuser,    // [0] req_type
  input  wire logic [PIX_W-1:0] in_tdata,    // [7:0] raw_sample
  output logic                  out_tvalid,
  input  wire logic             out_tready,
  output logic [RGB_W-1:0]      out_tdata,   // [7:0] red, [15:8] green, [23:16] blue
  output logic                  out_tlast,   // row_end
  output logic                  out_tuser,   // [0] frame_end
  input  wire logic             cfg_we,
  input  wire logic [0:0]       cfg_index,
  input  wire logic [CFG_W-1:0] cfg_wdata
);

  localparam int AW = $clog2(MAX_WIDTH);
  localparam int DW = AW + $bits(cmd_t);

  fifo_stat_t    fifo_stat;
  logic          cmd_push, cmd_pop;
  cmd_t          cmd, head_cmd;
  logic [AW-1:0] cmd_addr, head_addr;
  logic [DW-1:0] head_word;

  bbd_front #(
    .MAX_WIDTH (MAX_WIDTH),
    .AW        (AW)
  ) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tuser  (in_tuser),
    .in_tdata  (in_tdata),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .fifo_stat (fifo_stat),
    .cmd_push  (cmd_push),
    .cmd       (cmd),
    .cmd_addr  (cmd_addr)
  );

  bbd_cmd_fifo #(
    .DW (DW)
  ) u_fifo (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (cmd_push),
    .wdata ({cmd_addr, cmd}),
    .pop   (cmd_pop),
    .rdata (head_word),
    .stat  (fifo_stat)
  );

  assign head_addr = head_word[DW-1 -: AW];
  assign head_cmd  = cmd_t'(head_word[$bits(cmd_t)-1:0]);

  bbd_back #(
    .MAX_WIDTH (MAX_WIDTH),
    .AW        (AW)
  ) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .fifo_stat  (fifo_stat),
    .head_cmd   (head_cmd),
    .head_addr  (head_addr),
    .pop        (cmd_pop),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .out_tuser  (out_tuser)
  );

  // The front end never pushes a command into a full queue.
  a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n)
    cmd_push |-> !fifo_stat.full)
    else $error("command pushed into a full queue");

  // The back end never pops an empty queue.
  a_no_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
    cmd_pop |-> !fifo_stat.empty)
    else $error("command popped from an empty queue");

  // The last pixel of a frame is also the last of its row.
  a_frame_end_row_end: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tuser) |-> out_tlast)
    else $error("frame end without row end");

endmodule

`default_nettype wire

// ----- rtl/core/bbd_front.sv -----
// Front end: configuration registers, frame counters and item classification.
`default_nettype none

module bbd_front import bbd_pkg::*; #(
  parameter int MAX_WIDTH = DEF_MAX_WIDTH,
  parameter int AW        = $clog2(MAX_WIDTH)
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             in_tvalid,
  output logic                  in_tready,
  input  wire logic             in_tuser,   // [0] req_type
  input  wire logic [PIX_W-1:0] in_tdata,   // [7:0] raw_sample
  input  wire logic             cfg_we,
  input  wire logic [0:0]       cfg_index,
  input  wire logic [CFG_W-1:0] cfg_wdata,
  input  wire fifo_stat_t       fifo_stat,
  output logic                  cmd_push,
  output cmd_t                  cmd,
  output logic [AW-1:0]         cmd_addr
);

  localparam int MW_BITS = $clog2(MAX_WIDTH + 1);
  localparam int XW      = ((MW_BITS > CFG_W) ? MW_BITS : CFG_W) + 1;
  localparam int PW      = MW_BITS;
  localparam int RX      = ROW_W + 1;
  localparam logic [XW-1:0] MAXW_X = XW'(MAX_WIDTH);

  logic [CFG_W-1:0] fw_r, fh_r;
  logic [AW-1:0]    col_r, col_nxt, ocol_r, ocol_nxt;
  logic [ROW_W-1:0] row_r, row_nxt, orow_r, orow_nxt;
  logic [PW-1:0]    pend_r, pend_nxt;

  logic [XW-1:0]    w_eff, fw_x, col1_x, ocol1_x;
  logic [CFG_W-1:0] h_eff;
  logic [ROW_W-1:0] h_row;
  logic             accept, is_drain, frame_done, new_frame, drain_ok, do_cmd, emit;
  logic [AW-1:0]    col0, ocol0;
  logic [ROW_W-1:0] row0, orow0;
  logic [PW-1:0]    pend0;
  logic             right, bottom;

  assign in_tready = !fifo_stat.full;
  assign accept    = in_tvalid && in_tready;

  // Effective frame size: width clamped to [2, MAX_WIDTH], height to at least 2.
  always_comb begin
    fw_x = XW'(fw_r);
    if (fw_r < MIN_DIM) begin
      w_eff = XW'(MIN_DIM);
    end else if (fw_x > MAXW_X) begin
      w_eff = MAXW_X;
    end else begin
      w_eff = fw_x;
    end
    h_eff = (fh_r < MIN_DIM) ? MIN_DIM : fh_r;
    h_row = ROW_W'(h_eff);
  end

  // Classify the item and work out the next counter values.
  always_comb begin
    is_drain   = (req_type_t'(in_tuser) == REQ_DRAIN);
    frame_done = (row_r >= h_row);
    new_frame  = !is_drain && frame_done;
    drain_ok   = frame_done && (pend_r != '0);
    do_cmd     = !is_drain || drain_ok;

    col0  = new_frame ? '0 : col_r;
    row0  = new_frame ? '0 : row_r;
    pend0 = new_frame ? '0 : pend_r;
    ocol0 = new_frame ? '0 : ocol_r;
    orow0 = new_frame ? '0 : orow_r;

    // Input position advances on every pushed sample.
    col1_x = XW'(col0) + XW'(1);
    if (col1_x >= w_eff) begin
      col_nxt = '0;
      row_nxt = row0 + ROW_W'(1);
    end else begin
      col_nxt = col1_x[AW-1:0];
      row_nxt = row0;
    end

    // A sample releases a pixel once a row of samples is already held back; a drain always does.
    emit = is_drain ? 1'b1 : (XW'(pend0) >= w_eff);
    if (is_drain) begin
      pend_nxt = pend_r - PW'(1);
    end else if (emit) begin
      pend_nxt = pend0;
    end else begin
      pend_nxt = pend0 + PW'(1);
    end

    // Output position and its frame-edge flags.
    ocol1_x = XW'(ocol0) + XW'(1);
    right   = (ocol1_x >= w_eff);
    bottom  = ((RX'(orow0) + RX'(1)) >= RX'(h_row));
    if (!emit) begin
      ocol_nxt = ocol0;
      orow_nxt = orow0;
    end else if (right) begin
      ocol_nxt = '0;
      orow_nxt = orow0 + ROW_W'(1);
    end else begin
      ocol_nxt = ocol1_x[AW-1:0];
      orow_nxt = orow0;
    end

    cmd.sample        = is_drain ? '0 : in_tdata;
    cmd.emit          = emit;
    cmd.pos.row_odd   = orow0[0];
    cmd.pos.col_odd   = ocol0[0];
    cmd.pos.top       = (orow0 == '0);
    cmd.pos.bottom    = bottom;
    cmd.pos.left      = (ocol0 == '0);
    cmd.pos.right     = right;
    cmd.pos.row_end   = right;
    cmd.pos.frame_end = right && bottom;
    cmd_addr          = col0;
    cmd_push          = accept && do_cmd;
  end

  // Configuration registers and counters.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fw_r   <= FRAME_WIDTH_RST;
      fh_r   <= FRAME_HEIGHT_RST;
      col_r  <= '0;
      row_r  <= '0;
      pend_r <= '0;
      ocol_r <= '0;
      orow_r <= '0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_reg_t'(cfg_index))
          REG_FRAME_WIDTH:  fw_r <= cfg_wdata;
          REG_FRAME_HEIGHT: fh_r <= cfg_wdata;
          default: ;
        endcase
      end
      if (cmd_push) begin
        col_r  <= col_nxt;
        row_r  <= row_nxt;
        pend_r <= pend_nxt;
        ocol_r <= ocol_nxt;
        orow_r <= orow_nxt;
      end
    end
  end

endmodule

`default_nettype wire

// ----- rtl/core/bbd_cmd_fifo.sv -----
// Short command queue between the front end and the back end.
`default_nettype none

module bbd_cmd_fifo import bbd_pkg::*; #(
  parameter int DW = 8
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          push,
  input  wire logic [DW-1:0] wdata,
  input  wire logic          pop,
  output logic [DW-1:0]      rdata,
  output fifo_stat_t         stat
);

  logic [DW-1:0]      mem_r [FIFO_DEPTH];
  logic [FIFO_PW-1:0] wp_r, rp_r;
  logic [FIFO_PW:0]   cnt_r;

  assign stat.full  = (cnt_r == (FIFO_PW+1)'(FIFO_DEPTH));
  assign stat.empty = (cnt_r == '0);
  assign rdata      = mem_r[rp_r];

  // Pointers and fill level.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (push) begin
        wp_r <= wp_r + FIFO_PW'(1);
      end
      if (pop) begin
        rp_r <= rp_r + FIFO_PW'(1);
      end
      if (push && !pop) begin
        cnt_r <= cnt_r + (FIFO_PW+1)'(1);
      end else if (pop && !push) begin
        cnt_r <= cnt_r - (FIFO_PW+1)'(1);
      end
    end
  end

  // Entry storage.
  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wp_r] <= wdata;
    end
  end

endmodule

`default_nettype wire

// ----- rtl/core/bbd_back.sv -----
// Back end: line stores, 3x3 window, neighbour averaging and output register.
`default_nettype none

module bbd_back import bbd_pkg::*; #(
  parameter int MAX_WIDTH = DEF_MAX_WIDTH,
  parameter int AW        = $clog2(MAX_WIDTH)
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire fifo_stat_t  fifo_stat,
  input  wire cmd_t        head_cmd,
  input  wire logic [AW-1:0] head_addr,
  output logic             pop,
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [RGB_W-1:0] out_tdata,  // [7:0] red, [15:8] green, [23:16] blue
  output logic             out_tlast,  // row_end
  output logic             out_tuser   // [0] frame_end
);

  // Line stores: samples of the rows two and one above the input row.
  logic [PIX_W-1:0] upper_mem [MAX_WIDTH];
  logic [PIX_W-1:0] mid_mem   [MAX_WIDTH];

  // Stage A: command with its line-store read data.
  logic             a_vld_r;
  cmd_t             a_cmd_r;
  logic [AW-1:0]    a_addr_r;
  logic [PIX_W-1:0] rd_up_r, rd_mid_r;

  // Bypass of the most recent line-store write.
  logic             fwd_vld_r;
  logic [AW-1:0]    fwd_addr_r;
  logic [PIX_W-1:0] fwd_up_r, fwd_mid_r;

  logic [PIX_W-1:0] win_r [3][3];

  // Stage B: window ready, position of the pixel.
  logic      b_vld_r;
  pos_info_t b_pos_r;

  // Stage C: per-colour sums and counts.
  logic             c_vld_r;
  logic [SUM_W-1:0] c_sum_r [3];
  logic [CNT_W-1:0] c_cnt_r [3];
  colour_t          c_own_r;
  logic [PIX_W-1:0] c_ctr_r;
  logic             c_last_r, c_fend_r;

  // Stage D: output register.
  logic             d_vld_r;
  logic [PIX_W-1:0] d_red_r, d_green_r, d_blue_r;
  logic             d_last_r, d_fend_r;

  logic             a_go, b_go, c_go, fwd_hit;
  logic [PIX_W-1:0] up_eff, mid_eff;
  logic [SUM_W-1:0] sum_n [3];
  logic [CNT_W-1:0] cnt_n [3];
  logic [PIX_W-1:0] quot [3];
  logic [PIX_W-1:0] red_n, green_n, blue_n;

  function automatic logic [PIX_W-1:0] div_count(input logic [SUM_W-1:0] s,
                                                 input logic [CNT_W-1:0] n);
    logic [2*SUM_W-1:0] prod;
    logic [PIX_W-1:0]   q;
    prod = s * DIV3_MUL;
    unique case (n)
      CNT_W'(1): q = s[PIX_W-1:0];
      CNT_W'(2): q = s[PIX_W:1];
      CNT_W'(3): q = prod[DIV3_SHIFT +: PIX_W];
      CNT_W'(4): q = s[PIX_W+1:2];
      default:   q = '0;
    endcase
    return q;
  endfunction

  // Handshake between the stages.
  assign c_go = c_vld_r && (!d_vld_r || out_tready);
  assign b_go = b_vld_r && (!c_vld_r || c_go);
  assign a_go = a_vld_r && (!b_vld_r || b_go);
  assign pop  = !fifo_stat.empty && (!a_vld_r || a_go);

  assign fwd_hit = fwd_vld_r && (fwd_addr_r == a_addr_r);
  assign up_eff  = fwd_hit ? fwd_up_r  : rd_up_r;
  assign mid_eff = fwd_hit ? fwd_mid_r : rd_mid_r;

  // Line stores: read on pop, shifted down a row on the window update.
  always_ff @(posedge clk) begin
    if (pop) begin
      rd_up_r  <= upper_mem[head_addr];
      rd_mid_r <= mid_mem[head_addr];
    end
    if (a_go) begin
      upper_mem[a_addr_r] <= mid_eff;
      mid_mem[a_addr_r]   <= a_cmd_r.sample;
    end
  end

  // Neighbour sums per colour from the window, masked at the frame edges.
  always_comb begin
    logic    keep;
    colour_t ncol;
    for (int k = 0; k < 3; k++) begin
      sum_n[k] = '0;
      cnt_n[k] = '0;
    end
    for (int dr = 0; dr < 3; dr++) begin
      for (int dc = 0; dc < 3; dc++) begin
        keep = !(dr == 1 && dc == 1)
               && !(dr == 0 && b_pos_r.top) && !(dr == 2 && b_pos_r.bottom)
               && !(dc == 0 && b_pos_r.left) && !(dc == 2 && b_pos_r.right);
        ncol = site_colour(b_pos_r.row_odd ^ (dr != 1), b_pos_r.col_odd ^ (dc != 1));
        if (keep) begin
          unique case (ncol)
            COL_RED: begin
              sum_n[0] = sum_n[0] + SUM_W'(win_r[dr][dc]);
              cnt_n[0] = cnt_n[0] + CNT_W'(1);
            end
            COL_GREEN: begin
              sum_n[1] = sum_n[1] + SUM_W'(win_r[dr][dc]);
              cnt_n[1] = cnt_n[1] + CNT_W'(1);
            end
            COL_BLUE: begin
              sum_n[2] = sum_n[2] + SUM_W'(win_r[dr][dc]);
              cnt_n[2] = cnt_n[2] + CNT_W'(1);
            end
            default: ;
          endcase
        end
      end
    end
  end

  // Means of the missing colours; the site's own colour is its own sample.
  always_comb begin
    for (int k = 0; k < 3; k++) begin
      quot[k] = div_count(c_sum_r[k], c_cnt_r[k]);
    end
    red_n   = (c_own_r == COL_RED)   ? c_ctr_r : quot[0];
    green_n = (c_own_r == COL_GREEN) ? c_ctr_r : quot[1];
    blue_n  = (c_own_r == COL_BLUE)  ? c_ctr_r : quot[2];
  end

  // Stage valids, window and bypass.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_vld_r   <= 1'b0;
      b_vld_r   <= 1'b0;
      c_vld_r   <= 1'b0;
      d_vld_r   <= 1'b0;
      fwd_vld_r <= 1'b0;
      for (int r = 0; r < 3; r++) begin
        for (int c = 0; c < 3; c++) begin
          win_r[r][c] <= '0;
        end
      end
    end else begin
      if (pop) begin
        a_vld_r <= 1'b1;
      end else if (a_go) begin
        a_vld_r <= 1'b0;
      end
      if (a_go) begin
        b_vld_r   <= a_cmd_r.emit;
        fwd_vld_r <= 1'b1;
        for (int r = 0; r < 3; r++) begin
          win_r[r][0] <= win_r[r][1];
          win_r[r][1] <= win_r[r][2];
        end
        win_r[0][2] <= up_eff;
        win_r[1][2] <= mid_eff;
        win_r[2][2] <= a_cmd_r.sample;
      end else if (b_go) begin
        b_vld_r <= 1'b0;
      end
      if (b_go) begin
        c_vld_r <= 1'b1;
      end else if (c_go) begin
        c_vld_r <= 1'b0;
      end
      if (c_go) begin
        d_vld_r <= 1'b1;
      end else if (out_tready) begin
        d_vld_r <= 1'b0;
      end
    end
  end

  // Stage payloads.
  always_ff @(posedge clk) begin
    if (pop) begin
      a_cmd_r  <= head_cmd;
      a_addr_r <= head_addr;
    end
    if (a_go) begin
      b_pos_r    <= a_cmd_r.pos;
      fwd_addr_r <= a_addr_r;
      fwd_up_r   <= mid_eff;
      fwd_mid_r  <= a_cmd_r.sample;
    end
    if (b_go) begin
      for (int k = 0; k < 3; k++) begin
        c_sum_r[k] <= sum_n[k];
        c_cnt_r[k] <= cnt_n[k];
      end
      c_own_r  <= site_colour(b_pos_r.row_odd, b_pos_r.col_odd);
      c_ctr_r  <= win_r[1][1];
      c_last_r <= b_pos_r.row_end;
      c_fend_r <= b_pos_r.frame_end;
    end
    if (c_go) begin
      d_red_r   <= red_n;
      d_green_r <= green_n;
      d_blue_r  <= blue_n;
      d_last_r  <= c_last_r;
      d_fend_r  <= c_fend_r;
    end
  end

  assign out_tvalid = d_vld_r;
  assign out_tdata  = {d_blue_r, d_green_r, d_red_r};
  assign out_tlast  = d_last_r;
  assign out_tuser  = d_fend_r;

endmodule

`default_nettype wire

// ----- test/tb_bayer_bilinear_demosaic_unit.sv -----
`timescale 1ns / 100ps
// Self-checking testbench of the Bayer bilinear demosaic unit, with an RGB scoreboard.

module tb_bayer_bilinear_demosaic_unit import bbd_pkg::*;;

  localparam int QUIET_LIMIT     = 2000;
  localparam int SETTLE_CYCLES   = 16;
  localparam int HOLD_OFF_CYCLES = 300;
  localparam int RANDOM_ITEMS    = 500;
  localparam int REPORT_LIMIT    = 200;

  // One output pixel as the checker sees it.
  typedef struct packed {
    logic [PIX_W-1:0] red;
    logic [PIX_W-1:0] green;
    logic [PIX_W-1:0] blue;
    logic             row_end;
    logic             frame_end;
  } pixel_t;

  // Keeps its own copy of the line stores and the window, and works out every pixel.
  class demosaic_scoreboard;
    logic [CFG_W-1:0] width_reg;
    logic [CFG_W-1:0] height_reg;
    logic [PIX_W-1:0] upper_line [DEF_MAX_WIDTH];
    logic [PIX_W-1:0] middle_line [DEF_MAX_WIDTH];
    logic [PIX_W-1:0] win [3][3];
    int unsigned      in_col;
    int unsigned      in_row;
    int unsigned      held;
    int unsigned      out_col;
    int unsigned      out_row;
    pixel_t           expected_pixels [$];
    int               errors;

    function new();
      width_reg  = FRAME_WIDTH_RST;
      height_reg = FRAME_HEIGHT_RST;
      foreach (upper_line[i]) begin
        upper_line[i]  = '0;
        middle_line[i] = '0;
      end
      foreach (win[r, c]) win[r][c] = '0;
      in_col  = 0;
      in_row  = 0;
      held    = 0;
      out_col = 0;
      out_row = 0;
      errors  = 0;
    endfunction

    function void write_reg(cfg_reg_t idx, logic [CFG_W-1:0] val);
      if (idx == REG_FRAME_WIDTH) width_reg = val;
      else height_reg = val;
    endfunction

    // Widths are clamped to the line store size, both sizes to at least two.
    function int unsigned active_width();
      if (width_reg < MIN_DIM) return MIN_DIM;
      if (width_reg > DEF_MAX_WIDTH) return DEF_MAX_WIDTH;
      return width_reg;
    endfunction

    function int unsigned active_height();
      return (height_reg < MIN_DIM) ? MIN_DIM : height_reg;
    endfunction

    // GBRG: even rows alternate green and blue, odd rows red and green.
    function colour_t colour_at(int unsigned r, int unsigned c);
      if (r % 2 == 0) return (c % 2 == 1) ? COL_BLUE : COL_GREEN;
      return (c % 2 == 1) ? COL_GREEN : COL_RED;
    endfunction

    // Pushes one sample through the line stores into the right column of the window.
    function void shift_in(logic [PIX_W-1:0] s, int unsigned w);
      int unsigned      c;
      int               k;
      logic [PIX_W-1:0] up;
      logic [PIX_W-1:0] mid;
      c   = (in_col < DEF_MAX_WIDTH) ? in_col : 0;
      up  = upper_line[c];
      mid = middle_line[c];
      upper_line[c]  = mid;
      middle_line[c] = s;
      for (k = 0; k < 3; k++) begin
        win[k][0] = win[k][1];
        win[k][1] = win[k][2];
      end
      win[0][2] = up;
      win[1][2] = mid;
      win[2][2] = s;
      in_col++;
      if (in_col >= w) begin
        in_col = 0;
        in_row = (in_row + 1) & 32'h1FFF;
      end
    endfunction

    // Bilinear estimate at the window centre, masking neighbours outside the frame.
    function pixel_t interpolate(int unsigned w, int unsigned h);
      int unsigned nb_sum [3];
      int unsigned nb_count [3];
      int unsigned level [3];
      int          dr;
      int          dc;
      int          ci;
      colour_t     own;
      colour_t     nb;
      pixel_t      px;
      nb_sum   = '{0, 0, 0};
      nb_count = '{0, 0, 0};
      own = colour_at(out_row, out_col);
      for (dr = -1; dr <= 1; dr++) begin
        for (dc = -1; dc <= 1; dc++) begin
          if (dr == 0 && dc == 0) continue;
          if (dr < 0 && out_row == 0) continue;
          if (dr > 0 && out_row + 1 >= h) continue;
          if (dc < 0 && out_col == 0) continue;
          if (dc > 0 && out_col + 1 >= w) continue;
          nb = colour_at(out_row + dr, out_col + dc);
          nb_sum[nb]   += win[dr + 1][dc + 1];
          nb_count[nb] += 1;
        end
      end
      for (ci = 0; ci < 3; ci++) begin
        if (ci == own) level[ci] = win[1][1];
        else level[ci] = (nb_count[ci] != 0) ? nb_sum[ci] / nb_count[ci] : 0;
      end
      px.red       = PIX_W'(level[COL_RED]);
      px.green     = PIX_W'(level[COL_GREEN]);
      px.blue      = PIX_W'(level[COL_BLUE]);
      px.row_end   = (out_col + 1 >= w);
      px.frame_end = px.row_end && (out_row + 1 >= h);
      out_col++;
      if (out_col >= w) begin
        out_col = 0;
        out_row = (out_row + 1) & 32'h1FFF;
      end
      return px;
    endfunction

    // Called for every accepted input item.
    function void note_item(req_type_t kind, logic [PIX_W-1:0] sample);
      int unsigned w;
      int unsigned h;
      w = active_width();
      h = active_height();
      if (kind == REQ_SAMPLE) begin
        // A sample after a complete frame starts the next one.
        if (in_row >= h) begin
          in_col  = 0;
          in_row  = 0;
          held    = 0;
          out_col = 0;
          out_row = 0;
        end
        shift_in(sample, w);
        held++;
        if (held > w) begin
          expected_pixels.push_back(interpolate(w, h));
          held--;
        end
      end else if (in_row >= h && held != 0) begin
        // Drain ticks only count once the frame is in and pixels remain.
        shift_in('0, w);
        expected_pixels.push_back(interpolate(w, h));
        held--;
      end
    endfunction

    function void compare_field(string name, int unsigned want, int unsigned got);
      if (want != got) begin
        if (errors < REPORT_LIMIT)
          $error("%s mismatch: expected %0d, actual %0d", name, want, got);
        errors++;
      end
    endfunction

    // Called for every accepted output pixel.
    function void check_pixel(pixel_t got);
      pixel_t want;
      if (expected_pixels.size() == 0) begin
        if (errors < REPORT_LIMIT)
          $error("pixel with none expected: red %0d green %0d blue %0d",
                 got.red, got.green, got.blue);
        errors++;
        return;
      end
      want = expected_pixels.pop_front();
      compare_field("red", want.red, got.red);
      compare_field("green", want.green, got.green);
      compare_field("blue", want.blue, got.blue);
      compare_field("row_end", want.row_end, got.row_end);
      compare_field("frame_end", want.frame_end, got.frame_end);
    endfunction
  endclass

  logic               clk        = 1'b0;
  logic               rst_n      = 1'b0;
  logic               in_tvalid  = 1'b0;
  logic               in_tready;
  logic               in_tuser   = 1'b0;
  logic [PIX_W-1:0]   in_tdata   = '0;
  logic               out_tvalid;
  logic               out_tready = 1'b0;
  logic [RGB_W-1:0]   out_tdata;
  logic               out_tlast;
  logic               out_tuser;
  logic               cfg_we     = 1'b0;
  logic [0:0]         cfg_index  = '0;
  logic [CFG_W-1:0]   cfg_wdata  = '0;

  demosaic_scoreboard sb = new();
  bit                 no_idle      = 1'b0;
  bit                 hold_request = 1'b0;
  int unsigned        counted_items;
  int                 quiet_cycles = 0;

  bayer_bilinear_demosaic_unit dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tuser   (in_tuser),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .out_tuser  (out_tuser),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata)
  );

  // 10 ns clock.
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Ends the run if neither side moves an item for too long.
  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("tb_bayer_bilinear_demosaic_unit NOT OK");
        $finish;
      end
    end
  end

  // Sample values weighted towards black and full scale.
  function automatic logic [PIX_W-1:0] rand_byte();
    int unsigned pick;
    pick = $urandom_range(0, 9);
    if (pick == 0) return '0;
    if (pick == 1) return '1;
    return $urandom_range(0, 255);
  endfunction

  // Offers one item after a random gap and notes it once accepted.
  task automatic send_item(req_type_t kind, logic [PIX_W-1:0] sample);
    int unsigned gap;
    gap = no_idle ? 0 : $urandom_range(0, 9);
    if (gap != 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= kind;
    in_tdata  <= sample;
    do @(posedge clk); while (!in_tready);
    sb.note_item(kind, sample);
  endtask

  // Stops offering, waits for every expected pixel, then lets the pipeline settle.
  task automatic wait_idle();
    in_tvalid <= 1'b0;
    while (sb.expected_pixels.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Writes both size registers on consecutive edges.
  task automatic set_frame(logic [CFG_W-1:0] w, logic [CFG_W-1:0] h);
    cfg_we    <= 1'b1;
    cfg_index <= REG_FRAME_WIDTH;
    cfg_wdata <= w;
    @(posedge clk);
    sb.write_reg(REG_FRAME_WIDTH, w);
    cfg_index <= REG_FRAME_HEIGHT;
    cfg_wdata <= h;
    @(posedge clk);
    sb.write_reg(REG_FRAME_HEIGHT, h);
    cfg_we <= 1'b0;
  endtask

  // One whole frame of random samples followed by a number of drain ticks.
  task automatic send_frame(int unsigned drains, bit noisy);
    int unsigned w;
    int unsigned h;
    w = sb.active_width();
    h = sb.active_height();
    for (int unsigned i = 0; i < w * h; i++) begin
      // Drain ticks inside a frame are ignored by the block.
      if (noisy && $urandom_range(0, 19) == 0) send_item(REQ_DRAIN, rand_byte());
      send_item(REQ_SAMPLE, rand_byte());
    end
    repeat (drains) send_item(REQ_DRAIN, rand_byte());
    counted_items += w * h + ((drains < w) ? drains : w);
  endtask

  // Output side: random back-pressure, one long hold-off on request.
  initial begin : receiver
    int unsigned gap;
    pixel_t      got;
    wait (rst_n === 1'b1);
    @(posedge clk);
    forever begin
      gap = no_idle ? 0 : $urandom_range(0, 9);
      if (hold_request) begin
        hold_request = 1'b0;
        gap = HOLD_OFF_CYCLES;
      end
      if (gap != 0) begin
        out_tready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      out_tready <= 1'b1;
      do @(posedge clk); while (!out_tvalid);
      got.red       = out_tdata[PIX_W-1:0];
      got.green     = out_tdata[2*PIX_W-1:PIX_W];
      got.blue      = out_tdata[3*PIX_W-1:2*PIX_W];
      got.row_end   = out_tlast;
      got.frame_end = out_tuser;
      sb.check_pixel(got);
    end
  end

  initial begin : stimulus
    int unsigned w;
    int unsigned h;
    int unsigned frame_no;
    int unsigned drains;
    bit          rewrite;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    // Directed: both registers below range, so the frame is 2x2.
    set_frame(12'd0, 12'd1);
    send_item(REQ_DRAIN, 8'hFF);
    send_item(REQ_SAMPLE, 8'h00);
    send_item(REQ_SAMPLE, 8'hFF);
    send_item(REQ_DRAIN, 8'h00);
    send_item(REQ_SAMPLE, 8'hFF);
    send_item(REQ_SAMPLE, 8'h00);
    send_item(REQ_DRAIN, 8'h5A);
    send_item(REQ_DRAIN, 8'hA5);
    send_item(REQ_DRAIN, 8'hFF);
    // Second frame left half drained, so starting the third drops the second's last pixel.
    send_item(REQ_SAMPLE, 8'hFF);
    send_item(REQ_SAMPLE, 8'h00);
    send_item(REQ_SAMPLE, 8'h00);
    send_item(REQ_SAMPLE, 8'hFF);
    send_item(REQ_DRAIN, 8'h00);
    repeat (4) send_item(REQ_SAMPLE, rand_byte());
    repeat (2) send_item(REQ_DRAIN, rand_byte());

    // One register below range per setting, one small frame each.
    wait_idle();
    set_frame(12'd1, 12'd2);
    send_frame(sb.active_width() + 1, 1'b0);
    wait_idle();
    set_frame(12'd3, 12'd0);
    send_frame(sb.active_width(), 1'b0);

    // Random frames of mostly small sizes.
    frame_no      = 0;
    counted_items = 0;
    while (counted_items < RANDOM_ITEMS) begin
      rewrite = (frame_no == 0) || (frame_no == 2) || ($urandom_range(0, 2) == 0);
      if (rewrite) begin
        wait_idle();
        if (frame_no == 2) begin
          w = 8;
          h = 8;
        end else begin
          w = ($urandom_range(0, 9) == 0) ? $urandom_range(13, 64) : $urandom_range(2, 12);
          h = $urandom_range(2, 8);
        end
        set_frame(CFG_W'(w), CFG_W'(h));
      end
      no_idle = (frame_no != 2) && ($urandom_range(0, 3) == 0);
      // Long output stall while the input keeps offering, so the queue fills.
      if (frame_no == 2) hold_request = 1'b1;
      if ($urandom_range(0, 5) == 0) drains = $urandom_range(0, sb.active_width() - 1);
      else drains = sb.active_width() + $urandom_range(0, 2);
      send_frame(drains, 1'b1);
      if (frame_no == 4) wait_idle();
      frame_no++;
    end

    no_idle = 1'b0;
    wait_idle();
    if (sb.errors == 0) begin
      $display("tb_bayer_bilinear_demosaic_unit OK");
    end else begin
      $display("tb_bayer_bilinear_demosaic_unit NOT OK");
    end
    $finish;
  end

endmodule
